[design/tftp_read_client_defines.svh]
// ---------------------------------------------------------------------------
// TFTP read client assertion macros
// Shared concurrent assertion forms for the TFTP read client modules.
// ---------------------------------------------------------------------------
`ifndef TFTP_READ_CLIENT_DEFINES_SVH
`define TFTP_READ_CLIENT_DEFINES_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define TFTP_ASSERT(label, clk_i, rst_ni, prop, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define TFTP_ASSERT_NEVER(label, clk_i, rst_ni, cond, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define TFTP_ASSERT(label, clk_i, rst_ni, prop, msg)
`define TFTP_ASSERT_NEVER(label, clk_i, rst_ni, cond, msg)

`endif

`endif

[design/tftp_pkg.sv]
// ---------------------------------------------------------------------------
// TFTP read client package
// Types and fixed codes shared by the front end, queue and back end.
// ---------------------------------------------------------------------------
package tftp_pkg;

	// request types on the input channel
	localparam logic [1:0] REQ_START   = 2'd0;
	localparam logic [1:0] REQ_PACKET  = 2'd1;
	localparam logic [1:0] REQ_TIMEOUT = 2'd2;

	// packet opcodes
	localparam logic [15:0] OP_DATA  = 16'd3;
	localparam logic [15:0] OP_ERROR = 16'd5;

	// send kinds
	localparam logic [1:0] SEND_NONE = 2'd0;
	localparam logic [1:0] SEND_RRQ  = 2'd1;
	localparam logic [1:0] SEND_ACK  = 2'd2;

	// status codes
	localparam logic [1:0] STAT_RUN     = 2'd0;
	localparam logic [1:0] STAT_DONE    = 2'd1;
	localparam logic [1:0] STAT_RESTART = 2'd2;

	// configuration register indexes
	localparam logic CFG_SERVER_PORT = 1'b0;
	localparam logic CFG_RETRY_LIMIT = 1'b1;

	localparam logic [15:0] RST_SERVER_PORT = 16'd69;
	localparam logic [7:0]  RST_RETRY_LIMIT = 8'd10;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_RRQ  = 2'd1,
		PH_DATA = 2'd2
	} phase_t;

	// event class decided by the front end
	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_START   = 3'd1,
		EV_ERROR   = 3'd2,
		EV_DATA    = 3'd3,
		EV_TIMEOUT = 3'd4
	} ev_kind_t;

	// queued event: port_a is local_port on start, dest_port on a packet
	typedef struct packed {
		ev_kind_t    kind;
		logic [15:0] port_a;
		logic [15:0] sport;
		logic [15:0] blk;
		logic [31:0] off;
		logic [15:0] plen;
		logic        short_blk;
		logic        clr_retry;
	} ev_t;

	typedef struct packed {
		logic [1:0]  send_kind;
		logic [15:0] send_dest_port;
		logic [15:0] send_src_port;
		logic [15:0] ack_block;
		logic        store_valid;
		logic [31:0] store_offset;
		logic [15:0] store_len;
		logic [1:0]  status;
		logic [31:0] xfer_size;
	} res_t;

endpackage

[design/tftp_read_client.sv]
// ---------------------------------------------------------------------------
// TFTP read client
// Receive-side control of a TFTP read transfer: phase, ports, blocks,
// retries, store commands and ACK/RRQ send commands.
// ---------------------------------------------------------------------------
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    req_type, ports, udp_len, opcode, block_num
// out       output     out_valid/out_ready  send command, store command, status, size
// cfg       input      cfg_we               cfg_idx, cfg_wdata
//
// One beat per cycle sustained while out_ready is high; a beat passes from input
// to output through the two-entry queue and then the result register.
// The back end updates all transfer state once per event.
// Reset clears state and the queue; config registers return to 69 and 10.
// A stalled output holds its result while the queue keeps taking input
// until it holds two events.
// ---------------------------------------------------------------------------
module tftp_read_client #(
	parameter int BLOCK_BYTES = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [15:0] local_port,
	input  logic [15:0] dest_port,
	input  logic [15:0] src_port,
	input  logic [15:0] udp_len,
	input  logic [15:0] opcode,
	input  logic [15:0] block_num,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  send_kind,
	output logic [15:0] send_dest_port,
	output logic [15:0] send_src_port,
	output logic [15:0] ack_block,
	output logic        store_valid,
	output logic [31:0] store_offset,
	output logic [15:0] store_len,
	output logic [1:0]  status,
	output logic [31:0] xfer_size
);

	tftp_pkg::ev_t  fe_ev;
	tftp_pkg::ev_t  head;
	tftp_pkg::res_t res;
	logic           q_full;
	logic           head_valid;
	logic           pop;

	assign in_ready = !q_full;

	tftp_front #(
		.BLOCK_BYTES(BLOCK_BYTES)
	) u_front (
		.req_type  (req_type),
		.local_port(local_port),
		.dest_port (dest_port),
		.src_port  (src_port),
		.udp_len   (udp_len),
		.opcode    (opcode),
		.block_num (block_num),
		.ev        (fe_ev)
	);

	tftp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && !q_full),
		.push_ev   (fe_ev),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	tftp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign send_kind      = res.send_kind;
	assign send_dest_port = res.send_dest_port;
	assign send_src_port  = res.send_src_port;
	assign ack_block      = res.ack_block;
	assign store_valid    = res.store_valid;
	assign store_offset   = res.store_offset;
	assign store_len      = res.store_len;
	assign status         = res.status;
	assign xfer_size      = res.xfer_size;

endmodule

[design/tftp_front.sv]
// ---------------------------------------------------------------------------
// TFTP front end
// Classifies an input beat and precomputes store offset, payload length,
// short-block flag and the retry-clear condition.
// ---------------------------------------------------------------------------
module tftp_front #(
	parameter int BLOCK_BYTES = 512
) (
	input  logic [1:0]   req_type,
	input  logic [15:0]  local_port,
	input  logic [15:0]  dest_port,
	input  logic [15:0]  src_port,
	input  logic [15:0]  udp_len,
	input  logic [15:0]  opcode,
	input  logic [15:0]  block_num,
	output tftp_pkg::ev_t ev
);

	tftp_pkg::ev_kind_t kind;
	logic [31:0] prod;
	logic [15:0] blk_m1;
	logic [5:0]  nib_sum;
	logic [4:0]  fold_sum;
	logic        by5;

	// classify the event; length checks do not depend on state
	always_comb begin
		kind = tftp_pkg::EV_NONE;
		unique case (req_type)
			tftp_pkg::REQ_START:   kind = tftp_pkg::EV_START;
			tftp_pkg::REQ_PACKET: begin
				if (udp_len >= 16'd2) begin
					if (opcode == tftp_pkg::OP_ERROR)
						kind = tftp_pkg::EV_ERROR;
					else if (opcode == tftp_pkg::OP_DATA && udp_len >= 16'd4)
						kind = tftp_pkg::EV_DATA;
				end
			end
			tftp_pkg::REQ_TIMEOUT: kind = tftp_pkg::EV_TIMEOUT;
			default:               kind = tftp_pkg::EV_NONE;
		endcase
	end

	// offset = (block-1)*BLOCK_BYTES mod 2^32, as block*B - B
	assign prod = 32'(block_num) * 32'(BLOCK_BYTES);

	// block == 1 mod 10: block-1 even and divisible by 5 (16 = 1 mod 5)
	assign blk_m1   = block_num - 16'd1;
	assign nib_sum  = 6'(blk_m1[3:0]) + 6'(blk_m1[7:4]) + 6'(blk_m1[11:8])
	                + 6'(blk_m1[15:12]);
	assign fold_sum = 5'(nib_sum[5:4]) + 5'(nib_sum[3:0]);
	assign by5      = (fold_sum == 5'd0) || (fold_sum == 5'd5) || (fold_sum == 5'd10)
	                || (fold_sum == 5'd15);

	assign ev.kind      = kind;
	assign ev.port_a    = (req_type == tftp_pkg::REQ_START) ? local_port : dest_port;
	assign ev.sport     = src_port;
	assign ev.blk       = block_num;
	assign ev.off       = prod - 32'(BLOCK_BYTES);
	assign ev.plen      = udp_len - 16'd4;
	assign ev.short_blk = {1'b0, ev.plen} < 17'(BLOCK_BYTES);
	assign ev.clr_retry = !blk_m1[0] && by5 && (block_num != 16'd0);

endmodule

[design/tftp_queue.sv]
// ---------------------------------------------------------------------------
// TFTP event queue
// Two-entry FIFO between front and back end so each side stalls on its own.
// ---------------------------------------------------------------------------
`include "tftp_read_client_defines.svh"

module tftp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tftp_pkg::ev_t push_ev,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output tftp_pkg::ev_t head
);

	tftp_pkg::ev_t ent_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = ent_q[rd_ptr_q];

	// entry storage, no reset needed
	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_ev;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	`TFTP_ASSERT_NEVER(a_cnt_range, clk, arst_n, count_q == 2'd3, "queue count out of range")
	`TFTP_ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && count_q == 2'd0, "pop from empty queue")
	`TFTP_ASSERT(a_ptr_track, clk, arst_n, (count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q), "queue pointers out of step")

endmodule

[design/tftp_back.sv]
// ---------------------------------------------------------------------------
// TFTP back end
// Holds transfer state and config registers, applies one queued event per
// cycle while the output is not stalled, and registers the result beat.
// ---------------------------------------------------------------------------
`include "tftp_read_client_defines.svh"

module tftp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_idx,
	input  logic [15:0]    cfg_wdata,
	input  logic           head_valid,
	input  tftp_pkg::ev_t  head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output tftp_pkg::res_t res
);

	logic [15:0]      cfg_port_q;
	logic [7:0]       retry_limit_q;

	tftp_pkg::phase_t phase_q, phase_d;
	logic [15:0]      server_q, server_d;
	logic [15:0]      our_q, our_d;
	logic [7:0]       retry_q, retry_d;
	logic [15:0]      cur_q, cur_d;
	logic [15:0]      prev_q, prev_d;
	logic [31:0]      size_q, size_d;

	logic             out_valid_q;
	tftp_pkg::res_t   res_q, res_d;

	logic             is_start, port_ok, err_hit, dat_hit, bad_first, fresh_hit;
	logic             tmo_hit, give_up;
	logic [15:0]      prev_eff;
	logic [7:0]       retry_inc;
	logic [31:0]      new_size;

	assign pop       = head_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign res       = res_q;

	// decision terms for the head event
	assign is_start  = head.kind == tftp_pkg::EV_START;
	assign port_ok   = (phase_q != tftp_pkg::PH_IDLE) && (head.port_a == our_q)
	                 && (phase_q == tftp_pkg::PH_RRQ || head.sport == server_q);
	assign err_hit   = (head.kind == tftp_pkg::EV_ERROR) && port_ok;
	assign dat_hit   = (head.kind == tftp_pkg::EV_DATA) && port_ok;
	assign bad_first = dat_hit && (phase_q == tftp_pkg::PH_RRQ) && (head.blk != 16'd1);
	assign prev_eff  = (phase_q == tftp_pkg::PH_RRQ) ? 16'd0 : prev_q;
	assign fresh_hit = dat_hit && !bad_first && (head.blk != prev_eff);
	assign tmo_hit   = (head.kind == tftp_pkg::EV_TIMEOUT) && (phase_q != tftp_pkg::PH_IDLE);
	assign retry_inc = (retry_q == 8'hFF) ? retry_q : retry_q + 8'd1;
	assign give_up   = tmo_hit && (retry_inc >= retry_limit_q);
	assign new_size  = head.off + 32'(head.plen);

	// next phase
	always_comb begin
		phase_d = phase_q;
		priority if (is_start)
			phase_d = tftp_pkg::PH_RRQ;
		else if (err_hit || bad_first || give_up)
			phase_d = tftp_pkg::PH_IDLE;
		else if (dat_hit)
			phase_d = tftp_pkg::PH_DATA;
	end

	// state updates and result beat
	always_comb begin
		server_d = server_q;
		our_d    = our_q;
		retry_d  = retry_q;
		cur_d    = cur_q;
		prev_d   = prev_q;
		size_d   = size_q;
		res_d    = '0;
		if (is_start) begin
			server_d = cfg_port_q;
			our_d    = head.port_a;
			retry_d  = 8'd0;
			size_d   = 32'd0;
			res_d.send_kind      = tftp_pkg::SEND_RRQ;
			res_d.send_dest_port = cfg_port_q;
			res_d.send_src_port  = head.port_a;
		end
		if (err_hit)
			res_d.status = tftp_pkg::STAT_RESTART;
		if (dat_hit) begin
			cur_d = head.blk;
			if (head.clr_retry)
				retry_d = 8'd0;
			if (phase_q == tftp_pkg::PH_RRQ) begin
				server_d = head.sport;
				prev_d   = 16'd0;
			end
			if (bad_first)
				res_d.status = tftp_pkg::STAT_RESTART;
		end
		if (fresh_hit) begin
			prev_d = head.blk;
			if (size_q < new_size)
				size_d = new_size;
			// server port equals the source port here in both phases
			res_d.send_kind      = tftp_pkg::SEND_ACK;
			res_d.send_dest_port = head.sport;
			res_d.send_src_port  = our_q;
			res_d.ack_block      = head.blk;
			res_d.store_valid    = 1'b1;
			res_d.store_offset   = head.off;
			res_d.store_len      = head.plen;
			if (head.short_blk)
				res_d.status = tftp_pkg::STAT_DONE;
		end
		if (tmo_hit) begin
			retry_d = retry_inc;
			if (give_up) begin
				res_d.status = tftp_pkg::STAT_RESTART;
			end else begin
				res_d.send_dest_port = server_q;
				res_d.send_src_port  = our_q;
				if (phase_q == tftp_pkg::PH_RRQ) begin
					res_d.send_kind = tftp_pkg::SEND_RRQ;
				end else begin
					res_d.send_kind = tftp_pkg::SEND_ACK;
					res_d.ack_block = cur_q;
				end
			end
		end
		res_d.xfer_size = size_d;
	end

	// config registers and transfer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_port_q    <= tftp_pkg::RST_SERVER_PORT;
			retry_limit_q <= tftp_pkg::RST_RETRY_LIMIT;
			phase_q       <= tftp_pkg::PH_IDLE;
			server_q      <= 16'd0;
			our_q         <= 16'd0;
			retry_q       <= 8'd0;
			cur_q         <= 16'd0;
			prev_q        <= 16'd0;
			size_q        <= 32'd0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					tftp_pkg::CFG_SERVER_PORT: cfg_port_q    <= cfg_wdata;
					tftp_pkg::CFG_RETRY_LIMIT: retry_limit_q <= cfg_wdata[7:0];
					default: ;
				endcase
			end
			if (pop) begin
				phase_q  <= phase_d;
				server_q <= server_d;
				our_q    <= our_d;
				retry_q  <= retry_d;
				cur_q    <= cur_d;
				prev_q   <= prev_d;
				size_q   <= size_d;
			end
			out_valid_q <= pop || (out_valid_q && !out_ready);
		end
	end

	// result register, loaded when a beat is produced
	always_ff @(posedge clk) begin
		if (pop)
			res_q <= res_d;
	end

	`TFTP_ASSERT(a_start_rrq, clk, arst_n, (pop && is_start) |=> (phase_q == tftp_pkg::PH_RRQ), "start did not arm the transfer")
	`TFTP_ASSERT(a_size_mono, clk, arst_n, (pop && !is_start) |=> (size_q >= $past(size_q)), "transfer size went down")
	`TFTP_ASSERT(a_store_ack, clk, arst_n, (out_valid_q && res_q.store_valid) |-> (res_q.send_kind == tftp_pkg::SEND_ACK), "store without ACK")

endmodule
